// File: src/rrc_pkg.sv
// shared types and constants for the rational reduce and compare block
package rrc_pkg;
	localparam int IN_WIDTH = 32;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] first_numerator;
		logic signed [IN_WIDTH-1:0] first_denominator;
		logic signed [IN_WIDTH-1:0] second_numerator;
		logic signed [IN_WIDTH-1:0] second_denominator;
	} rrc_in_t;

	typedef struct packed {
		logic is_equal;
		logic signed [IN_WIDTH-1:0] reduced_numerator;
		logic signed [IN_WIDTH-1:0] reduced_denominator;
		logic invalid;
	} rrc_out_t;

	typedef struct packed {
		logic load;
		logic sel_second;
		logic gcd_step;
		logic div_start;
		logic [1:0] div_sel;
		logic finish;
	} rrc_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
	} rrc_sts_t;

	localparam logic [1:0] DSEL_NUM = 2'd0;
	localparam logic [1:0] DSEL_DEN = 2'd1;
	localparam logic [1:0] DSEL_REM = 2'd2;
endpackage

// File: src/rrc_if.sv
// valid/ready channel interface
interface rrc_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/rrc_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
module rrc_div import rrc_pkg::*; #(parameter int W = 32) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic done,
	output logic signed [W-1:0] quo,
	output logic signed [W-1:0] rem
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic [W-1:0] q_q, r_q, d_q;
	logic nq_q, nr_q, busy_q, done_q;
	logic [W:0] trial;
	logic [W-1:0] rs;
	logic [W-1:0] ua, ub;

	assign ua = a[W-1] ? W'(-a) : W'(a);
	assign ub = b[W-1] ? W'(-b) : W'(b);
	assign rs = {r_q[W-2:0], q_q[W-1]};
	assign trial = {r_q, q_q[W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= ua;
			r_q <= '0;
			d_q <= ub;
			nq_q <= a[W-1] ^ b[W-1];
			nr_q <= a[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = nq_q ? W'(-q_q) : W'(q_q);
	assign rem = nr_q ? W'(-r_q) : W'(r_q);
endmodule

// File: src/rrc_datapath.sv
// datapath: operand registers, gcd registers, divider and result logic
module rrc_datapath import rrc_pkg::*; #(parameter int W = 32) (
	input  logic clk,
	input  logic arst_n,
	input  rrc_cmd_t cmd,
	output rrc_sts_t sts,
	input  logic [IN_WIDTH-1:0] in_n1,
	input  logic [IN_WIDTH-1:0] in_d1,
	input  logic [IN_WIDTH-1:0] in_n2,
	input  logic [IN_WIDTH-1:0] in_d2,
	output logic res_eq,
	output logic [IN_WIDTH-1:0] res_num,
	output logic [IN_WIDTH-1:0] res_den,
	output logic res_inv
);
	logic signed [W-1:0] n1_q, d1_q, n2_q, d2_q, a_q, b_q, g_q, rn_q, rd_q;
	logic signed [W-1:0] on_q, od_q;
	logic ok1_q;
	logic signed [W-1:0] cur_n, cur_d, div_a, div_b, quo, rem, mn, fn, fd;
	logic ok, neg;

	assign mn = {1'b1, {(W-1){1'b0}}};
	assign cur_n = cmd.sel_second ? n2_q : n1_q;
	assign cur_d = cmd.sel_second ? d2_q : d1_q;
	assign div_a = (cmd.div_sel == DSEL_REM) ? a_q :
		(cmd.div_sel == DSEL_NUM) ? cur_n : cur_d;
	assign div_b = (cmd.div_sel == DSEL_REM) ? b_q : g_q;

	rrc_div #(.W(W)) u_div (.clk, .arst_n, .start(cmd.div_start), .a(div_a), .b(div_b),
		.done(sts.div_done), .quo, .rem);

	assign sts.gcd_done = (b_q == '0);

	// final sign move and validity of one rational
	always_comb begin
		ok = 1'b1;
		fn = rn_q;
		fd = rd_q;
		if (g_q == '0) ok = 1'b0;
		else if (g_q == '1) begin
			if (cur_n == mn || cur_d == mn) ok = 1'b0;
			fn = W'(-cur_n);
			fd = W'(-cur_d);
		end else if ((cur_n == mn || cur_d == mn) && g_q == '1) ok = 1'b0;
		neg = fd[W-1];
		if (neg) begin
			if (fn == mn || fd == mn) ok = 1'b0;
			fn = W'(-fn);
			fd = W'(-fd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_eq <= 1'b0;
			res_inv <= 1'b0;
			ok1_q <= 1'b0;
		end else if (cmd.finish) begin
			if (!cmd.sel_second) ok1_q <= ok;
			else begin
				res_eq <= ok1_q && ok && on_q == fn && od_q == fd;
				res_inv <= !(ok1_q && ok);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n1_q <= W'($signed(in_n1));
			d1_q <= W'($signed(in_d1));
			n2_q <= W'($signed(in_n2));
			d2_q <= W'($signed(in_d2));
			a_q <= W'($signed(in_n1));
			b_q <= W'($signed(in_d1));
		end else if (cmd.finish && !cmd.sel_second) begin
			a_q <= n2_q;
			b_q <= d2_q;
		end else if (cmd.gcd_step) begin
			a_q <= b_q;
			b_q <= (b_q == '1) ? '0 : rem;
		end
		if (sts.gcd_done) g_q <= a_q;
		if (sts.div_done && cmd.div_sel == DSEL_NUM) rn_q <= quo;
		if (sts.div_done && cmd.div_sel == DSEL_DEN) rd_q <= quo;
		if (cmd.finish && !cmd.sel_second) begin
			on_q <= fn;
			od_q <= fd;
		end
		if (cmd.finish && cmd.sel_second) begin
			res_num <= IN_WIDTH'(ok1_q && ok && on_q == fn && od_q == fd ? on_q : '0);
			res_den <= IN_WIDTH'(ok1_q && ok && on_q == fn && od_q == fd ? od_q : '0);
		end
	end
endmodule

// File: src/rrc_ctrl.sv
// control state machine sequencing gcd, divisions and compare
module rrc_ctrl import rrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output rrc_cmd_t cmd,
	input  rrc_sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0, S_GCD = 3'd1, S_GWAIT = 3'd2, S_DN = 3'd3,
		S_DD = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6, S_GSET = 3'd7;
	logic [2:0] state_q;
	logic sec_q, kick_q, ov_q;

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		cmd.sel_second = sec_q;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_GCD: begin
				cmd.div_sel = DSEL_REM;
				cmd.div_start = !sts.gcd_done;
			end
			S_GWAIT: begin
				cmd.div_sel = DSEL_REM;
				cmd.gcd_step = sts.div_done;
			end
			S_DN: begin
				cmd.div_sel = DSEL_NUM;
				cmd.div_start = kick_q;
			end
			S_DD: begin
				cmd.div_sel = DSEL_DEN;
				cmd.div_start = kick_q;
			end
			S_FIN: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sec_q <= 1'b0;
			kick_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			kick_q <= 1'b0;
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd.load) begin
					state_q <= S_GCD;
					sec_q <= 1'b0;
				end
				S_GCD: state_q <= sts.gcd_done ? S_GSET : S_GWAIT;
				S_GWAIT: if (sts.div_done) state_q <= S_GCD;
				S_GSET: begin
					state_q <= S_DN;
					kick_q <= 1'b1;
				end
				S_DN: if (sts.div_done) begin
					state_q <= S_DD;
					kick_q <= 1'b1;
				end
				S_DD: if (sts.div_done) state_q <= S_FIN;
				S_FIN: begin
					if (sec_q) begin
						state_q <= S_OUT;
					end else begin
						sec_q <= 1'b1;
						state_q <= S_GCD;
					end
				end
				S_OUT: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/rational_reduce_and_compare.sv
// top level of the rational reduce and compare block
//  channel  dir  fields
//  in       in   first/second numerator and denominator, 32 bits signed each
//  out      out  is_equal, reduced_numerator, reduced_denominator, invalid
// one item at a time on a shared restoring divider
// the result register holds until taken; the next item is taken after that
// arst_n clears all control state; no clearing pass
module rational_reduce_and_compare import rrc_pkg::*; #(parameter int VALUE_WIDTH = 32) (
	input logic clk,
	input logic arst_n,
	rrc_if.sink in,
	rrc_if.source out
);
	rrc_cmd_t cmd;
	rrc_sts_t sts;
	logic eq, inv;
	logic [IN_WIDTH-1:0] rn, rd;

	rrc_ctrl u_ctrl (.clk, .arst_n, .in_valid(in.valid), .in_ready(in.ready),
		.out_valid(out.valid), .out_ready(out.ready), .cmd, .sts);

	rrc_datapath #(.W(VALUE_WIDTH)) u_dp (.clk, .arst_n, .cmd, .sts,
		.in_n1(in.data.first_numerator), .in_d1(in.data.first_denominator),
		.in_n2(in.data.second_numerator), .in_d2(in.data.second_denominator),
		.res_eq(eq), .res_num(rn), .res_den(rd), .res_inv(inv));

	assign out.data.is_equal = eq;
	assign out.data.reduced_numerator = rn;
	assign out.data.reduced_denominator = rd;
	assign out.data.invalid = inv;
endmodule

// File: src/rrc_checker.sv
// port checker for the rational reduce and compare block
module rrc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_equal,
	input logic invalid
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_equal && invalid)) else $error("equal and invalid");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");
endmodule

bind rational_reduce_and_compare rrc_checker u_chk (.clk, .arst_n,
	.in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
	.out_ready(out.ready), .is_equal(out.data.is_equal), .invalid(out.data.invalid));
